// ===== hw/rtl/lrsc_pkg.sv =====
// Shared types and constants for the lidar ray caster.
// No dependencies; imported by every module of the block.
package lrsc_pkg;

    // default table depths
    localparam int OBSTACLE_SLOTS_DEF = 8;
    localparam int DRONE_SLOTS_DEF    = 8;

    // field widths
    localparam int POS_W  = 24;
    localparam int DIR_W  = 16;
    localparam int RAD_W  = 16;
    localparam int DIST_W = 23;
    localparam int HIT_W  = 27;
    localparam int NUM_W  = 25;
    localparam int QUO_W  = 39;

    // command codes
    localparam logic [1:0] CMD_WR_OBS = 2'd0;
    localparam logic [1:0] CMD_WR_DRN = 2'd1;
    localparam logic [1:0] CMD_CAST   = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_X_LO  = 3'd0;
    localparam logic [2:0] CFG_X_HI  = 3'd1;
    localparam logic [2:0] CFG_Y_LO  = 3'd2;
    localparam logic [2:0] CFG_Y_HI  = 3'd3;
    localparam logic [2:0] CFG_Z_LO  = 3'd4;
    localparam logic [2:0] CFG_Z_HI  = 3'd5;
    localparam logic [2:0] CFG_RANGE = 3'd6;
    localparam logic [2:0] CFG_DRAD  = 3'd7;

    typedef struct packed {
        logic [1:0]              command;
        logic [5:0]              slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [RAD_W-1:0]        sphere_radius;
        logic                    entry_valid;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              inside_flag;
    } t_out_word;

    // one sphere as held in a cell
    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] cz;
        logic [RAD_W-1:0]        rad;
        logic                    en;
    } t_entry;

    typedef struct packed {
        logic             done;
        logic             in_sph;
        logic             hit_ok;
        logic [HIT_W-1:0] hit;
    } t_sph_res;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

// ===== hw/rtl/lrsc_cell.sv =====
// One cell of the sphere chain: holds a table entry and a shift stage.
// Depends on lrsc_pkg.
module lrsc_cell
    import lrsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  t_entry           i_wr_entry,
    input  logic             i_load,
    input  logic             i_shift,
    input  logic             i_keep,
    input  logic             i_rad_ovr,
    input  logic [RAD_W-1:0] i_rad,
    input  t_entry           i_next,
    output t_entry           o_stage
);

    t_entry r_store;
    logic   r_valid;
    t_entry r_stage;
    t_entry n_stage;

    // entry storage, contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_store <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= i_wr_entry.en;
        end
    end

    // load own entry, or take the neighbour's
    always_comb begin
        n_stage = r_stage;
        if (i_load) begin
            n_stage    = r_store;
            n_stage.en = r_valid & i_keep;
            if (i_rad_ovr) begin
                n_stage.rad = i_rad;
            end
        end else if (i_shift) begin
            n_stage = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/lrsc_sphere.sv =====
// Ray/sphere test: shared 28x28 multiplier then a bit-serial square root.
// Depends on lrsc_pkg.
module lrsc_sphere
    import lrsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_entry                  i_entry,
    input  logic signed [POS_W-1:0] i_org_x,
    input  logic signed [POS_W-1:0] i_org_y,
    input  logic signed [POS_W-1:0] i_org_z,
    input  logic signed [DIR_W-1:0] i_dir_x,
    input  logic signed [DIR_W-1:0] i_dir_y,
    input  logic signed [DIR_W-1:0] i_dir_z,
    output t_sph_res                o_res
);

    localparam int L_W     = POS_W + 1;
    localparam int MUL_W   = 28;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int L2_W    = 52;
    localparam int TCA22_W = 42;
    localparam int R2_W    = 2 * RAD_W;
    localparam int ROOT_W  = 28;
    localparam int REM_W   = ROOT_W + 3;
    localparam logic [4:0] MUL_LAST  = 5'd8;
    localparam logic [4:0] SQRT_LAST = 5'(ROOT_W - 1);

    typedef enum logic [2:0] {
        SP_IDLE = 3'b001,
        SP_MUL  = 3'b010,
        SP_SQRT = 3'b100
    } t_sp_state;

    t_sp_state                 r_state;
    logic [4:0]                r_step;
    logic signed [L_W-1:0]     r_lx, r_ly, r_lz;
    logic signed [DIR_W-1:0]   r_dx, r_dy, r_dz;
    logic [RAD_W-1:0]          r_rad;
    logic signed [PROD_W-1:0]  r_prod;
    logic [L2_W-1:0]           r_l2;
    logic signed [TCA22_W-1:0] r_tca22;
    logic [R2_W-1:0]           r_r2;
    logic [HIT_W-1:0]          r_tca;
    logic [PROD_W-1:0]         r_sv;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_W-1:0]         r_root;
    t_sph_res                  r_res;

    logic signed [MUL_W-1:0]   w_opa, w_opb;
    logic signed [TCA22_W-1:0] w_tca_sum;
    logic [HIT_W-1:0]          w_tca;
    logic                      w_inside;
    logic [PROD_W-1:0]         w_sum;
    logic                      w_far;
    logic [REM_W-1:0]          w_rem_sh, w_trial, w_rem_n;
    logic [ROOT_W-1:0]         w_root_n;
    logic signed [HIT_W+1:0]   w_hit;

    // closest approach along the ray, rounded to Q8
    assign w_tca_sum = r_tca22 + 42'sd8192;
    assign w_tca     = w_tca_sum[40:14];

    // multiplier operand selection
    always_comb begin
        case (r_step)
            5'd0: begin w_opa = MUL_W'(r_lx); w_opb = MUL_W'(r_lx); end
            5'd1: begin w_opa = MUL_W'(r_ly); w_opb = MUL_W'(r_ly); end
            5'd2: begin w_opa = MUL_W'(r_lz); w_opb = MUL_W'(r_lz); end
            5'd3: begin w_opa = MUL_W'(r_lx); w_opb = MUL_W'(r_dx); end
            5'd4: begin w_opa = MUL_W'(r_ly); w_opb = MUL_W'(r_dy); end
            5'd5: begin w_opa = MUL_W'(r_lz); w_opb = MUL_W'(r_dz); end
            5'd6: begin
                w_opa = $signed({12'b0, r_rad});
                w_opb = $signed({12'b0, r_rad});
            end
            5'd7: begin
                w_opa = $signed({1'b0, w_tca});
                w_opb = $signed({1'b0, w_tca});
            end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end

    // decision once tca^2 sits in the product register
    assign w_inside = r_l2 <= {20'b0, r_r2};
    assign w_sum    = {24'b0, r_r2} + {2'b0, r_prod[53:0]};
    assign w_far    = {4'b0, r_l2} > w_sum;

    // one root bit per cycle
    assign w_rem_sh = {r_rem[ROOT_W:0], r_sv[PROD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    always_comb begin
        if (w_rem_sh >= w_trial) begin
            w_rem_n  = w_rem_sh - w_trial;
            w_root_n = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            w_rem_n  = w_rem_sh;
            w_root_n = {r_root[ROOT_W-2:0], 1'b0};
        end
    end
    assign w_hit = $signed({2'b0, r_tca}) - $signed({1'b0, w_root_n});

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        r_prod     <= w_opa * w_opb;
        r_res.done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= SP_IDLE;
            r_step  <= '0;
            r_res   <= '0;
        end else begin
            unique case (r_state)
                SP_IDLE: begin
                    if (i_start) begin
                        r_lx    <= L_W'(i_entry.cx) - L_W'(i_org_x);
                        r_ly    <= L_W'(i_entry.cy) - L_W'(i_org_y);
                        r_lz    <= L_W'(i_entry.cz) - L_W'(i_org_z);
                        r_dx    <= i_dir_x;
                        r_dy    <= i_dir_y;
                        r_dz    <= i_dir_z;
                        r_rad   <= i_entry.rad;
                        r_step  <= '0;
                        r_state <= SP_MUL;
                    end
                end
                SP_MUL: begin
                    r_step <= r_step + 5'd1;
                    case (r_step) inside
                        5'd1:       r_l2 <= r_prod[L2_W-1:0];
                        5'd2, 5'd3: r_l2 <= r_l2 + r_prod[L2_W-1:0];
                        5'd4:       r_tca22 <= r_prod[TCA22_W-1:0];
                        5'd5, 5'd6: r_tca22 <= r_tca22 + $signed(r_prod[TCA22_W-1:0]);
                        5'd7: begin
                            r_r2  <= r_prod[R2_W-1:0];
                            r_tca <= w_tca;
                        end
                        default: ;
                    endcase
                    if (r_step == MUL_LAST) begin
                        if (w_inside) begin
                            r_res   <= '{done: 1'b1, in_sph: 1'b1, hit_ok: 1'b0, hit: '0};
                            r_state <= SP_IDLE;
                        end else if (r_tca22[TCA22_W-1] || w_far) begin
                            r_res   <= '{done: 1'b1, in_sph: 1'b0, hit_ok: 1'b0, hit: '0};
                            r_state <= SP_IDLE;
                        end else begin
                            r_sv    <= w_sum - {4'b0, r_l2};
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_step  <= '0;
                            r_state <= SP_SQRT;
                        end
                    end
                end
                SP_SQRT: begin
                    r_sv   <= {r_sv[PROD_W-3:0], 2'b00};
                    r_rem  <= w_rem_n;
                    r_root <= w_root_n;
                    r_step <= r_step + 5'd1;
                    if (r_step == SQRT_LAST) begin
                        r_res.done   <= 1'b1;
                        r_res.in_sph <= 1'b0;
                        r_res.hit_ok <= !w_hit[HIT_W+1] && (w_hit != '0);
                        r_res.hit    <= w_hit[HIT_W-1:0];
                        r_state      <= SP_IDLE;
                    end
                end
                default: r_state <= SP_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/lrsc_div.sv =====
// Restoring divider for plane distances: (num << 14) / den, one bit a cycle.
// Depends on lrsc_pkg.
module lrsc_div
    import lrsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIR_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int REM_W = DIR_W + 1;
    localparam logic [5:0] LAST = 6'(QUO_W - 1);

    logic             r_run;
    logic [5:0]       r_cnt;
    logic [QUO_W-1:0] r_dd;
    logic [QUO_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [DIR_W-1:0] r_den;
    t_div_res         r_res;

    logic [REM_W-1:0] w_rem_sh;
    logic             w_ge;

    assign w_rem_sh = {r_rem[DIR_W-1:0], r_dd[QUO_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        r_res.done <= 1'b0;
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
            r_res <= '0;
        end else if (!r_run) begin
            if (i_start) begin
                r_dd  <= {i_num, 14'b0};
                r_den <= i_den;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end
        end else begin
            // one quotient bit
            r_dd  <= {r_dd[QUO_W-2:0], 1'b0};
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == LAST) begin
                r_run      <= 1'b0;
                r_res.done <= 1'b1;
                r_res.quo  <= {r_quo[QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/lidar_ray_sphere_box_caster_top.sv =====
// Lidar ray caster top: APB registers, sphere cell chain and cast sequencer.
// Depends on lrsc_pkg, lrsc_cell, lrsc_sphere and lrsc_div.
//
// A write word (obstacle or drone entry) is taken with busy staying low.
// A cast word raises busy until its single result word is shown on o_res
// with o_res_valid high for one cycle; the receiver cannot stall it, so it
// must take the word in that cycle. A cast walks all OBSTACLE_SLOTS+DRONE_SLOTS
// chain cells; each enabled sphere adds its products through the shared
// multiplier and a 28-bit serial root, and each box plane that is tested
// adds a 39-bit serial divide. Other commands give no result word.
module lidar_ray_sphere_box_caster_top
    import lrsc_pkg::*;
#(
    parameter int OBSTACLE_SLOTS = OBSTACLE_SLOTS_DEF,
    parameter int DRONE_SLOTS    = DRONE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_word,
    output logic        o_res_valid,
    output t_out_word   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TOTAL = OBSTACLE_SLOTS + DRONE_SLOTS;
    localparam int CNT_W = $clog2(TOTAL + 1);
    localparam logic [1:0] AXIS_END = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SPH   = 5'b00010,
        ST_SWAIT = 5'b00100,
        ST_PLANE = 5'b01000,
        ST_PWAIT = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [1:0]              r_axis;
    logic [DIST_W-1:0]       r_best;
    logic                    r_inside;
    logic signed [POS_W-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic                    r_out_valid;
    t_out_word               r_out;

    logic signed [POS_W-1:0] r_cfg_xlo, r_cfg_xhi, r_cfg_ylo;
    logic signed [POS_W-1:0] r_cfg_yhi, r_cfg_zlo, r_cfg_zhi;
    logic [DIST_W-1:0]       r_cfg_range;
    logic [RAD_W-1:0]        r_cfg_drad;

    logic     w_acc, w_load, w_shift, w_sph_start, w_div_start, w_chain_end;
    t_entry   w_wr_entry;
    t_entry   w_stage [TOTAL];
    t_sph_res w_sph_res;
    t_div_res w_div_res;

    logic signed [POS_W-1:0] w_p_org, w_p_lo, w_p_hi;
    logic signed [DIR_W-1:0] w_p_dir;
    logic                    w_p_pos, w_p_go;
    logic signed [NUM_W-1:0] w_p_num;
    logic [DIR_W-1:0]        w_p_den;

    assign busy   = r_state != ST_IDLE;
    assign w_acc  = start && !busy;
    assign w_load = w_acc && (i_word.command == CMD_CAST);
    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_xlo   <= -24'sd12800;
            r_cfg_xhi   <= 24'sd12800;
            r_cfg_ylo   <= 24'sd0;
            r_cfg_yhi   <= 24'sd25600;
            r_cfg_zlo   <= -24'sd12800;
            r_cfg_zhi   <= 24'sd12800;
            r_cfg_range <= 23'd7680;
            r_cfg_drad  <= 16'd128;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                CFG_X_LO:  r_cfg_xlo   <= pwdata[POS_W-1:0];
                CFG_X_HI:  r_cfg_xhi   <= pwdata[POS_W-1:0];
                CFG_Y_LO:  r_cfg_ylo   <= pwdata[POS_W-1:0];
                CFG_Y_HI:  r_cfg_yhi   <= pwdata[POS_W-1:0];
                CFG_Z_LO:  r_cfg_zlo   <= pwdata[POS_W-1:0];
                CFG_Z_HI:  r_cfg_zhi   <= pwdata[POS_W-1:0];
                CFG_RANGE: r_cfg_range <= pwdata[DIST_W-1:0];
                CFG_DRAD:  r_cfg_drad  <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            CFG_X_LO:  prdata = {8'b0, r_cfg_xlo};
            CFG_X_HI:  prdata = {8'b0, r_cfg_xhi};
            CFG_Y_LO:  prdata = {8'b0, r_cfg_ylo};
            CFG_Y_HI:  prdata = {8'b0, r_cfg_yhi};
            CFG_Z_LO:  prdata = {8'b0, r_cfg_zlo};
            CFG_Z_HI:  prdata = {8'b0, r_cfg_zhi};
            CFG_RANGE: prdata = {9'b0, r_cfg_range};
            CFG_DRAD:  prdata = {16'b0, r_cfg_drad};
            default:   prdata = '0;
        endcase
    end

    // sphere chain: obstacles first, then drones; cell 0 feeds the tester
    assign w_wr_entry = '{cx: i_word.pos_x, cy: i_word.pos_y, cz: i_word.pos_z,
                          rad: i_word.sphere_radius, en: i_word.entry_valid};

    for (genvar g = 0; g < TOTAL; g++) begin : g_cell
        logic   w_wr, w_keep, w_ovr;
        t_entry w_next;
        if (g < OBSTACLE_SLOTS) begin : g_obs
            assign w_wr   = w_acc && (i_word.command == CMD_WR_OBS)
                            && (i_word.slot == 6'(g));
            assign w_keep = 1'b1;
            assign w_ovr  = 1'b0;
        end else begin : g_drn
            assign w_wr   = w_acc && (i_word.command == CMD_WR_DRN)
                            && (i_word.slot == 6'(g - OBSTACLE_SLOTS));
            // the caster's own slot is left out
            assign w_keep = i_word.slot != 6'(g - OBSTACLE_SLOTS);
            assign w_ovr  = 1'b1;
        end
        if (g == TOTAL - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_stage[g + 1];
        end
        lrsc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (w_wr),
            .i_wr_entry (w_wr_entry),
            .i_load     (w_load),
            .i_shift    (w_shift),
            .i_keep     (w_keep),
            .i_rad_ovr  (w_ovr),
            .i_rad      (r_cfg_drad),
            .i_next     (w_next),
            .o_stage    (w_stage[g])
        );
    end

    assign w_chain_end = r_cnt == CNT_W'(TOTAL);
    assign w_sph_start = (r_state == ST_SPH) && !w_chain_end && w_stage[0].en;
    assign w_shift     = ((r_state == ST_SPH) && !w_chain_end && !w_stage[0].en)
                         || ((r_state == ST_SWAIT) && w_sph_res.done);

    lrsc_sphere u_sphere (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sph_start),
        .i_entry (w_stage[0]),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .i_org_z (r_org_z),
        .i_dir_x (r_dir_x),
        .i_dir_y (r_dir_y),
        .i_dir_z (r_dir_z),
        .o_res   (w_sph_res)
    );

    // plane operands for the current axis
    always_comb begin
        case (r_axis)
            2'd0: begin
                w_p_org = r_org_x; w_p_dir = r_dir_x;
                w_p_lo = r_cfg_xlo; w_p_hi = r_cfg_xhi;
            end
            2'd1: begin
                w_p_org = r_org_y; w_p_dir = r_dir_y;
                w_p_lo = r_cfg_ylo; w_p_hi = r_cfg_yhi;
            end
            2'd2: begin
                w_p_org = r_org_z; w_p_dir = r_dir_z;
                w_p_lo = r_cfg_zlo; w_p_hi = r_cfg_zhi;
            end
            default: begin
                w_p_org = '0; w_p_dir = '0; w_p_lo = '0; w_p_hi = '0;
            end
        endcase
    end

    // magnitude of the direction; the most negative value maps to 2^15
    assign w_p_pos = !w_p_dir[DIR_W-1] && (w_p_dir != '0);
    assign w_p_num = w_p_pos ? (NUM_W'(w_p_hi) - NUM_W'(w_p_org))
                             : (NUM_W'(w_p_org) - NUM_W'(w_p_lo));
    assign w_p_den = w_p_pos ? w_p_dir : -w_p_dir;
    assign w_p_go  = (w_p_dir != '0) && !w_p_num[NUM_W-1] && (w_p_num != '0);
    assign w_div_start = (r_state == ST_PLANE) && (r_axis != AXIS_END) && w_p_go;

    lrsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_p_num[NUM_W-1:0]),
        .i_den   (w_p_den),
        .o_res   (w_div_res)
    );

    // cast sequencer
    always_ff @(posedge i_clk) begin
        r_out_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_axis   <= '0;
            r_inside <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_org_x  <= i_word.pos_x;
                        r_org_y  <= i_word.pos_y;
                        r_org_z  <= i_word.pos_z;
                        r_dir_x  <= i_word.dir_x;
                        r_dir_y  <= i_word.dir_y;
                        r_dir_z  <= i_word.dir_z;
                        r_best   <= r_cfg_range;
                        r_inside <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= ST_SPH;
                    end
                end
                ST_SPH: begin
                    if (w_chain_end) begin
                        r_axis  <= '0;
                        r_state <= ST_PLANE;
                    end else if (w_stage[0].en) begin
                        r_state <= ST_SWAIT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_SWAIT: begin
                    if (w_sph_res.done) begin
                        if (w_sph_res.in_sph) begin
                            r_inside <= 1'b1;
                        end else if (w_sph_res.hit_ok
                                     && (w_sph_res.hit < {4'b0, r_best})) begin
                            r_best <= w_sph_res.hit[DIST_W-1:0];
                        end
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= ST_SPH;
                    end
                end
                ST_PLANE: begin
                    if (r_axis == AXIS_END) begin
                        r_out_valid       <= 1'b1;
                        r_out.distance    <= r_inside ? '0 : r_best;
                        r_out.inside_flag <= r_inside;
                        r_state           <= ST_IDLE;
                    end else if (w_p_go) begin
                        r_state <= ST_PWAIT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                ST_PWAIT: begin
                    if (w_div_res.done) begin
                        if ((w_div_res.quo != '0) && (w_div_res.quo < {16'b0, r_best})) begin
                            r_best <= w_div_res.quo[DIST_W-1:0];
                        end
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_PLANE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // checks
    a_res_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.inside_flag) |-> (o_res.distance == '0))
        else $error("inside result with non-zero distance");

    a_sph_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sph_res.done |-> (r_state == ST_SWAIT))
        else $error("sphere result outside its wait state");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |-> (r_state == ST_PWAIT))
        else $error("divider result outside its wait state");

    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while a cast is still running");

endmodule

// ===== tb/tb_lidar_ray_sphere_box_caster_top.sv =====
// Self-checking testbench for the lidar ray caster: drives command words, predicts each cast.
// Depends on lrsc_pkg and lidar_ray_sphere_box_caster_top.
module tb_lidar_ray_sphere_box_caster_top
    import lrsc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OBS_N = OBSTACLE_SLOTS_DEF;
    localparam int DRN_N = DRONE_SLOTS_DEF;
    localparam int IDLE_LIMIT = 20000;
    // command code with no meaning to the block
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_word = '0;
    logic        o_res_valid;
    t_out_word   o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lidar_ray_sphere_box_caster_top dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the block's registers and tables
    longint box_lo[3], box_hi[3];
    longint range_lim, drone_rad;
    longint obs_x[OBS_N], obs_y[OBS_N], obs_z[OBS_N], obs_r[OBS_N];
    bit     obs_on[OBS_N];
    longint drn_x[DRN_N], drn_y[DRN_N], drn_z[DRN_N];
    bit     drn_on[DRN_N];

    // current ray while predicting
    longint ray_o[3], ray_d[3], nearest;

    t_out_word ranges_due[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;

    function automatic longint floor_root(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // returns 1 when the origin is inside or on the sphere
    function automatic bit sphere_probe(longint cx, longint cy, longint cz, longint rad);
        longint lx, ly, lz, l2, r2, t22, tca, d2, hit;
        lx = cx - ray_o[0];
        ly = cy - ray_o[1];
        lz = cz - ray_o[2];
        l2 = lx * lx + ly * ly + lz * lz;
        r2 = rad * rad;
        if (l2 <= r2) return 1'b1;
        t22 = lx * ray_d[0] + ly * ray_d[1] + lz * ray_d[2];
        if (t22 < 0) return 1'b0;
        tca = (t22 + 8192) >>> 14;
        d2 = l2 - tca * tca;
        if (d2 > r2) return 1'b0;
        hit = tca - floor_root(r2 - d2);
        if (hit > 0 && hit < nearest) nearest = hit;
        return 1'b0;
    endfunction

    function automatic void plane_probe(int ax);
        longint num, den, t;
        if (ray_d[ax] > 0) begin
            num = box_hi[ax] - ray_o[ax];
            den = ray_d[ax];
        end else if (ray_d[ax] < 0) begin
            num = ray_o[ax] - box_lo[ax];
            den = -ray_d[ax];
        end else begin
            return;
        end
        if (num <= 0) return;
        t = (num * 16384) / den;
        if (t > 0 && t < nearest) nearest = t;
    endfunction

    function automatic t_out_word cast_ray(t_in_word w);
        t_out_word res;
        bit hit_in;
        hit_in = 1'b0;
        ray_o[0] = longint'($signed(w.pos_x));
        ray_o[1] = longint'($signed(w.pos_y));
        ray_o[2] = longint'($signed(w.pos_z));
        ray_d[0] = longint'($signed(w.dir_x));
        ray_d[1] = longint'($signed(w.dir_y));
        ray_d[2] = longint'($signed(w.dir_z));
        nearest = range_lim;
        for (int i = 0; i < OBS_N; i++)
            if (obs_on[i] && sphere_probe(obs_x[i], obs_y[i], obs_z[i], obs_r[i]))
                hit_in = 1'b1;
        for (int i = 0; i < DRN_N; i++)
            if (i != int'(w.slot) && drn_on[i] &&
                sphere_probe(drn_x[i], drn_y[i], drn_z[i], drone_rad))
                hit_in = 1'b1;
        for (int a = 0; a < 3; a++) plane_probe(a);
        res.distance = hit_in ? '0 : nearest[DIST_W-1:0];
        res.inside_flag = hit_in;
        return res;
    endfunction

    function automatic void store_entry(t_in_word w);
        int s;
        s = int'(w.slot);
        if (w.command == CMD_WR_OBS && s < OBS_N) begin
            obs_x[s] = $signed(w.pos_x);
            obs_y[s] = $signed(w.pos_y);
            obs_z[s] = $signed(w.pos_z);
            obs_r[s] = w.sphere_radius;
            obs_on[s] = w.entry_valid;
        end else if (w.command == CMD_WR_DRN && s < DRN_N) begin
            drn_x[s] = $signed(w.pos_x);
            drn_y[s] = $signed(w.pos_y);
            drn_z[s] = $signed(w.pos_z);
            drn_on[s] = w.entry_valid;
        end
    endfunction

    // hold the word until the block takes it; start is left high unless a random gap follows
    task automatic send_word(t_in_word w);
        start <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (w.command == CMD_CAST) ranges_due.push_back(cast_ray(w));
        else store_entry(w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (ranges_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        case (idx)
            CFG_X_LO:  box_lo[0] = val;
            CFG_X_HI:  box_hi[0] = val;
            CFG_Y_LO:  box_lo[1] = val;
            CFG_Y_HI:  box_hi[1] = val;
            CFG_Z_LO:  box_lo[2] = val;
            CFG_Z_HI:  box_hi[2] = val;
            CFG_RANGE: range_lim = val;
            default:   drone_rad = val;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_box(longint xl, longint xh, longint yl, longint yh,
                           longint zl, longint zh, longint rl, longint dr);
        write_reg(CFG_X_LO, xl);
        write_reg(CFG_X_HI, xh);
        write_reg(CFG_Y_LO, yl);
        write_reg(CFG_Y_HI, yh);
        write_reg(CFG_Z_LO, zl);
        write_reg(CFG_Z_HI, zh);
        write_reg(CFG_RANGE, rl);
        write_reg(CFG_DRAD, dr);
    endtask

    function automatic int spread(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic t_in_word make_word(logic [1:0] cmd, int s, int x, int y, int z,
                                           int dx, int dy, int dz, int rad, bit v);
        t_in_word w;
        w.command = cmd;
        w.slot = 6'(s);
        w.pos_x = 24'(x);
        w.pos_y = 24'(y);
        w.pos_z = 24'(z);
        w.dir_x = 16'(dx);
        w.dir_y = 16'(dy);
        w.dir_z = 16'(dz);
        w.sphere_radius = 16'(rad);
        w.entry_valid = v;
        return w;
    endfunction

    // cast with a roughly unit direction, sometimes with an axis zeroed
    function automatic t_in_word rand_cast(int reach);
        real a[3], n;
        int  c[3];
        n = 0.0;
        for (int k = 0; k < 3; k++) begin
            a[k] = ($urandom_range(0, 4) == 0) ? 0.0 : real'(spread(1000));
            n += a[k] * a[k];
        end
        if (n == 0.0) begin
            a[1] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int k = 0; k < 3; k++) c[k] = $rtoi(a[k] / n * 16384.0);
        return make_word(CMD_CAST, $urandom_range(0, 9), spread(reach), spread(reach),
                         spread(reach), c[0], c[1], c[2], $urandom, $urandom_range(0, 1));
    endfunction

    function automatic t_in_word rand_noise();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in_word)-1:0];
    endfunction

    // a mix of table writes, casts and junk, aimed at a region of given reach
    task automatic random_burst(int n, int reach);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_word(make_word(CMD_WR_OBS, $urandom_range(0, 9), spread(reach),
                                    spread(reach), spread(reach), 0, 0, 0,
                                    $urandom_range(50, 4000), $urandom_range(0, 3) != 0));
            else if (pick < 25)
                send_word(make_word(CMD_WR_DRN, $urandom_range(0, 9), spread(reach),
                                    spread(reach), spread(reach), 0, 0, 0, $urandom,
                                    $urandom_range(0, 3) != 0));
            else if (pick < 90)
                send_word(rand_cast(reach));
            else
                send_word(rand_noise());
        end
    endtask

    task automatic test_directed();
        send_word(make_word(CMD_CAST, 0, 0, 100, 0, 0, 16384, 0, 0, 0));
        send_word(make_word(CMD_WR_OBS, 0, 0, 2560, 0, 0, 0, 0, 512, 1'b1));
        send_word(make_word(CMD_WR_OBS, 7, -1280, 1280, 2560, 0, 0, 0, 65535, 1'b0));
        send_word(make_word(CMD_WR_OBS, 63, 8388607, -8388608, 8388607, 0, 0, 0, 65535, 1'b1));
        send_word(make_word(CMD_WR_DRN, 3, 2560, 1280, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(CMD_WR_DRN, 40, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(CMD_SPARE, 2, 0, 0, 0, 16384, 0, 0, 0, 1'b1));
        // straight up into the obstacle, then from inside it
        send_word(make_word(CMD_CAST, 0, 0, 100, 0, 0, 16384, 0, 0, 0));
        send_word(make_word(CMD_CAST, 0, 0, 2500, 0, 0, 16384, 0, 0, 0));
        // toward the drone, from its own slot and from outside the table
        send_word(make_word(CMD_CAST, 1, 0, 1280, 0, 16384, 0, 0, 0, 0));
        send_word(make_word(CMD_CAST, 3, 0, 1280, 0, 16384, 0, 0, 0, 0));
        send_word(make_word(CMD_CAST, 63, 0, 1280, 0, 16384, 0, 0, 0, 0));
        // origin on and beyond a plane, negative and diagonal rays
        send_word(make_word(CMD_CAST, 0, 12800, 1280, 0, 16384, 0, 0, 0, 0));
        send_word(make_word(CMD_CAST, 0, -20000, 1280, 0, -16384, 0, 0, 0, 0));
        send_word(make_word(CMD_CAST, 0, 100, 100, 100, -9459, -9459, -9459, 0, 0));
        // non-unit and extreme directions and positions
        send_word(make_word(CMD_CAST, 0, 0, 1280, 0, 32767, -32768, 1, 0, 0));
        send_word(make_word(CMD_CAST, 0, 8388607, 8388607, 8388607, -16384, 0, 0, 0, 0));
        send_word(make_word(CMD_CAST, 0, -8388608, -8388608, -8388608, 16384, 16384, 16384,
                            0, 0));
        send_word(make_word(CMD_CAST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_WR_OBS, 0, 0, 2560, 0, 0, 0, 0, 512, 1'b0));
        send_word(make_word(CMD_CAST, 0, 0, 2500, 0, 0, 16384, 0, 0, 0));
    endtask

    task automatic test_default_box();
        random_burst(90, 15000);
    endtask

    task automatic test_random_box();
        drain();
        set_box(-spread(20000) - 20000, spread(20000) + 20000, -spread(5000) - 5000,
                spread(20000) + 20000, -spread(20000) - 20000, spread(20000) + 20000,
                $urandom_range(1000, 100000), $urandom_range(0, 2000));
        random_burst(90, 20000);
    endtask

    task automatic test_extreme_box();
        drain();
        set_box(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 8388607, 65535);
        random_burst(80, 4000000);
        drain();
        set_box(8388607, -8388608, 0, 0, -1, 1, 0, 0);
        random_burst(60, 15000);
    endtask

    task automatic test_steady_flow();
        drain();
        set_box(-12800, 12800, 0, 25600, -12800, 12800, 7680, 128);
        gaps_on = 1'b0;
        random_burst(110, 15000);
    endtask

    // results come out unprompted; compare each against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_res_valid) begin
            if (ranges_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", o_res);
            end else begin
                want = ranges_due.pop_front();
                if (o_res.distance !== want.distance ||
                    o_res.inside_flag !== want.inside_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range mismatch: want dist %0d inside %0b, got %0d %0b",
                                 want.distance, want.inside_flag,
                                 o_res.distance, o_res.inside_flag);
                end
            end
        end
    end

    // watchdog on cycles with neither an accepted word nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_lidar_ray_sphere_box_caster_top: FAIL");
            $finish;
        end
    end

    initial begin
        box_lo = '{-12800, 0, -12800};
        box_hi = '{12800, 25600, 12800};
        range_lim = 7680;
        drone_rad = 128;
        obs_on = '{default: 1'b0};
        drn_on = '{default: 1'b0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_box(-12800, 12800, 0, 25600, -12800, 12800, 7680, 128);
        test_directed();
        test_default_box();
        test_random_box();
        test_extreme_box();
        test_steady_flow();
        drain();
        repeat (800) @(posedge i_clk);
        if (mismatches == 0 && ranges_due.size() == 0)
            $display("tb_lidar_ray_sphere_box_caster_top: PASS");
        else
            $display("tb_lidar_ray_sphere_box_caster_top: FAIL");
        $finish;
    end
endmodule
